### hw/rtl/avcdcr_pkg.sv
`timescale 1ns / 1ps

package avcdcr_pkg;

  // queue depths between the parts; each must be at least two
  localparam int MidDepth = 2;
  localparam int OutDepth = 2;

  // reserved bit patterns in the length-size and SPS-count bytes
  localparam logic [5:0] Res6Ones = 6'h3F;
  localparam logic [2:0] Res3Ones = 3'd7;

  // result kinds
  localparam logic [3:0] KIND_VERSION  = 4'd0;
  localparam logic [3:0] KIND_PROFILE  = 4'd1;
  localparam logic [3:0] KIND_COMPAT   = 4'd2;
  localparam logic [3:0] KIND_LEVEL    = 4'd3;
  localparam logic [3:0] KIND_LENSIZE  = 4'd4;
  localparam logic [3:0] KIND_SPSCOUNT = 4'd5;
  localparam logic [3:0] KIND_LENGTH   = 4'd6;
  localparam logic [3:0] KIND_SPSBYTE  = 4'd7;
  localparam logic [3:0] KIND_PPSCOUNT = 4'd8;
  localparam logic [3:0] KIND_PPSBYTE  = 4'd9;
  localparam logic [3:0] KIND_PENDING  = 4'd10;
  localparam logic [3:0] KIND_IGNORED  = 4'd11;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RES6_BAD  = 2'd1;
  localparam logic [1:0] ST_RES3_BAD  = 2'd2;
  localparam logic [1:0] ST_TRUNCATED = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_record;
  } in_item_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_record;
    logic       res6_ok;
    logic       res3_ok;
  } cls_item_t;

  typedef struct packed {
    logic [3:0]  item_kind;
    logic [15:0] field_value;
    logic [7:0]  set_index;
    logic        is_pps_length;
    logic        last_of_set;
    logic [1:0]  status;
    logic        record_complete;
  } out_item_t;

endpackage

### hw/rtl/avcdcr_fifo.sv
`timescale 1ns / 1ps

module avcdcr_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/avcdcr_front.sv
`timescale 1ns / 1ps

module avcdcr_front
  import avcdcr_pkg::*;
#(
  parameter int Depth = MidDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  in_item_t  item_i,
  output logic      full_o,
  input  logic      pop_i,
  output cls_item_t cls_o,
  output logic      empty_o
);

  cls_item_t cls_in;
  logic [$bits(cls_item_t)-1:0] q_rdata;

  // check both reserved groups up front; the back picks the one its phase needs
  always_comb begin
    cls_in.data_byte     = item_i.data_byte;
    cls_in.end_of_record = item_i.end_of_record;
    cls_in.res6_ok       = (item_i.data_byte[7:2] == Res6Ones);
    cls_in.res3_ok       = (item_i.data_byte[7:5] == Res3Ones);
  end

  avcdcr_fifo #(
    .Width($bits(cls_item_t)),
    .Depth(Depth)
  ) u_mid_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .wdata_i(cls_in),
    .full_o (full_o),
    .pop_i  (pop_i),
    .rdata_o(q_rdata),
    .empty_o(empty_o)
  );

  assign cls_o = q_rdata;

endmodule

### hw/rtl/avcdcr_back.sv
`timescale 1ns / 1ps

module avcdcr_back
  import avcdcr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cls_item_t cls_i,
  input  logic      cls_empty_i,
  output logic      cls_pop_o,
  output out_item_t res_o,
  output logic      res_push_o,
  input  logic      res_full_i
);

  typedef enum logic [13:0] {
    PH_VER  = 14'b00000000000001,
    PH_PROF = 14'b00000000000010,
    PH_COMP = 14'b00000000000100,
    PH_LEV  = 14'b00000000001000,
    PH_LSZ  = 14'b00000000010000,
    PH_SPSN = 14'b00000000100000,
    PH_SHI  = 14'b00000001000000,
    PH_SLO  = 14'b00000010000000,
    PH_SBY  = 14'b00000100000000,
    PH_PPSN = 14'b00001000000000,
    PH_PHI  = 14'b00010000000000,
    PH_PLO  = 14'b00100000000000,
    PH_PBY  = 14'b01000000000000,
    PH_DONE = 14'b10000000000000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  sets_left_q, sets_left_d;
  logic [7:0]  set_counter_q, set_counter_d;
  logic [15:0] bytes_left_q, bytes_left_d;
  logic [7:0]  length_high_q, length_high_d;
  logic        discard_q, discard_d;

  logic        fire, errored, pps, set_end;
  logic [7:0]  sets_dec;
  logic [15:0] full_len, bytes_dec;
  logic [7:0]  b;

  assign fire       = !cls_empty_i && !res_full_i;
  assign cls_pop_o  = fire;
  assign res_push_o = fire;
  assign b          = cls_i.data_byte;
  assign sets_dec   = sets_left_q - 8'd1;
  assign full_len   = {length_high_q, b};
  assign bytes_dec  = bytes_left_q - 16'd1;

  always_comb begin
    phase_d       = phase_q;
    sets_left_d   = sets_left_q;
    set_counter_d = set_counter_q;
    bytes_left_d  = bytes_left_q;
    length_high_d = length_high_q;
    discard_d     = discard_q;
    errored       = 1'b0;
    pps           = 1'b0;
    set_end       = 1'b0;

    res_o.item_kind       = KIND_IGNORED;
    res_o.field_value     = {8'd0, b};
    res_o.set_index       = '0;
    res_o.is_pps_length   = 1'b0;
    res_o.last_of_set     = 1'b0;
    res_o.status          = ST_OK;
    res_o.record_complete = 1'b0;

    if (!discard_q) begin
      case (phase_q)
        PH_VER: begin
          res_o.item_kind = KIND_VERSION;
          phase_d = PH_PROF;
        end
        PH_PROF: begin
          res_o.item_kind = KIND_PROFILE;
          phase_d = PH_COMP;
        end
        PH_COMP: begin
          res_o.item_kind = KIND_COMPAT;
          phase_d = PH_LEV;
        end
        PH_LEV: begin
          res_o.item_kind = KIND_LEVEL;
          phase_d = PH_LSZ;
        end
        PH_LSZ: begin
          res_o.item_kind   = KIND_LENSIZE;
          res_o.field_value = {14'd0, b[1:0]};
          if (!cls_i.res6_ok) begin
            res_o.status = ST_RES6_BAD;
            errored      = 1'b1;
            discard_d    = 1'b1;
          end else begin
            phase_d = PH_SPSN;
          end
        end
        PH_SPSN: begin
          res_o.item_kind   = KIND_SPSCOUNT;
          res_o.field_value = {11'd0, b[4:0]};
          if (!cls_i.res3_ok) begin
            res_o.status = ST_RES3_BAD;
            errored      = 1'b1;
            discard_d    = 1'b1;
          end else begin
            sets_left_d   = {3'd0, b[4:0]};
            set_counter_d = '0;
            phase_d       = (b[4:0] == 5'd0) ? PH_PPSN : PH_SHI;
          end
        end
        PH_PPSN: begin
          res_o.item_kind = KIND_PPSCOUNT;
          sets_left_d     = b;
          set_counter_d   = '0;
          if (b == 8'd0) begin
            phase_d               = PH_DONE;
            res_o.record_complete = 1'b1;
          end else begin
            phase_d = PH_PHI;
          end
        end
        PH_SHI, PH_PHI: begin
          res_o.item_kind = KIND_PENDING;
          res_o.set_index = set_counter_q;
          length_high_d   = b;
          phase_d         = (phase_q == PH_SHI) ? PH_SLO : PH_PLO;
        end
        PH_SLO, PH_PLO: begin
          pps                 = (phase_q == PH_PLO);
          res_o.item_kind     = KIND_LENGTH;
          res_o.set_index     = set_counter_q;
          res_o.is_pps_length = pps;
          res_o.field_value   = full_len;
          bytes_left_d        = full_len;
          if (full_len == 16'd0) begin
            res_o.last_of_set = 1'b1;
            set_end           = 1'b1;
          end else begin
            phase_d = pps ? PH_PBY : PH_SBY;
          end
        end
        PH_SBY, PH_PBY: begin
          pps             = (phase_q == PH_PBY);
          res_o.item_kind = pps ? KIND_PPSBYTE : KIND_SPSBYTE;
          res_o.set_index = set_counter_q;
          bytes_left_d    = bytes_dec;
          if (bytes_dec == 16'd0) begin
            res_o.last_of_set = 1'b1;
            set_end           = 1'b1;
          end
        end
        default: begin
          res_o.item_kind = KIND_IGNORED;
        end
      endcase

      // advance past a finished set
      if (set_end) begin
        sets_left_d = sets_dec;
        if (sets_dec == 8'd0) begin
          set_counter_d         = '0;
          phase_d               = pps ? PH_DONE : PH_PPSN;
          res_o.record_complete = pps;
        end else begin
          set_counter_d = set_counter_q + 8'd1;
          phase_d       = pps ? PH_PHI : PH_SHI;
        end
      end

      if (cls_i.end_of_record && !errored && phase_d != PH_DONE) begin
        res_o.status = ST_TRUNCATED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_VER;
      sets_left_q   <= '0;
      set_counter_q <= '0;
      bytes_left_q  <= '0;
      length_high_q <= '0;
      discard_q     <= 1'b0;
    end else if (fire) begin
      // every record end restarts at the version byte
      if (cls_i.end_of_record) begin
        phase_q       <= PH_VER;
        sets_left_q   <= '0;
        set_counter_q <= '0;
        bytes_left_q  <= '0;
        length_high_q <= '0;
        discard_q     <= 1'b0;
      end else begin
        phase_q       <= phase_d;
        sets_left_q   <= sets_left_d;
        set_counter_q <= set_counter_d;
        bytes_left_q  <= bytes_left_d;
        length_high_q <= length_high_d;
        discard_q     <= discard_d;
      end
    end
  end

endmodule

### hw/rtl/avc_decoder_config_record_parser.sv
`timescale 1ns / 1ps

// Channel  | Handshake             | Payload
// ---------+-----------------------+-------------------------------
// input    | push / full           | item_i   (in_item_t: byte, end flag)
// result   | empty / pop           | result_o (out_item_t: one per byte)
//
// One byte per cycle sustained while the result queue has room; one result per
// byte, in order. A byte is registered in the mid queue, and the phase machine
// then writes its result into the result queue, so empty falls once that
// write is made. With pop held low from empty, full rises once four bytes wait
// (two in the result queue, two in the mid queue).
// Reset (rst_ni low) empties both queues and sets the parser to the version byte.

module avc_decoder_config_record_parser
  import avcdcr_pkg::*;
#(
  parameter int MidQDepth = MidDepth,
  parameter int OutQDepth = OutDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  input  in_item_t  item_i,
  output logic      full,
  output logic      empty,
  input  logic      pop,
  output out_item_t result_o
);

  cls_item_t cls;
  logic      cls_empty, cls_pop;
  out_item_t res;
  logic      res_push, res_full;
  logic [$bits(out_item_t)-1:0] out_rdata;

  avcdcr_front #(
    .Depth(MidQDepth)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (item_i),
    .full_o (full),
    .pop_i  (cls_pop),
    .cls_o  (cls),
    .empty_o(cls_empty)
  );

  avcdcr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cls_i      (cls),
    .cls_empty_i(cls_empty),
    .cls_pop_o  (cls_pop),
    .res_o      (res),
    .res_push_o (res_push),
    .res_full_i (res_full)
  );

  avcdcr_fifo #(
    .Width($bits(out_item_t)),
    .Depth(OutQDepth)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(out_rdata),
    .empty_o(empty)
  );

  assign result_o = out_rdata;

`ifndef SYNTHESIS
  a_ignored_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.item_kind == KIND_IGNORED) |->
      (result_o.status == ST_OK && !result_o.record_complete))
    else $error("ignored byte carries status or completion");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.last_of_set) |->
      (result_o.item_kind == KIND_LENGTH || result_o.item_kind == KIND_SPSBYTE ||
       result_o.item_kind == KIND_PPSBYTE))
    else $error("last_of_set on a non-set item");

  a_res_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (result_o.status == ST_RES6_BAD || result_o.status == ST_RES3_BAD)) |->
      (result_o.item_kind == KIND_LENSIZE || result_o.item_kind == KIND_SPSCOUNT))
    else $error("reserved-bit status on wrong item kind");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && !res_full) |=> !empty)
    else $error("result queue empty after a transfer into it");
`endif

endmodule

### tb/record_parse_checker.sv
`timescale 1ns / 1ps

module record_parse_checker
  import avcdcr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  input  in_item_t  item_i,
  input  logic      full,
  input  logic      empty,
  input  logic      pop,
  input  out_item_t result_o,
  output int        mismatch_count_o,
  output int        outstanding_o
);

  typedef enum logic [3:0] {
    PH_VERSION, PH_PROFILE, PH_COMPAT, PH_LEVEL, PH_LENSIZE, PH_SPSCOUNT,
    PH_SPS_LEN_HI, PH_SPS_LEN_LO, PH_SPS_BODY, PH_PPSCOUNT,
    PH_PPS_LEN_HI, PH_PPS_LEN_LO, PH_PPS_BODY, PH_COMPLETE
  } parse_phase_e;

  parse_phase_e phase = PH_VERSION;
  logic [7:0]   sets_left = '0;
  logic [7:0]   set_num = '0;
  logic [15:0]  body_left = '0;
  logic [7:0]   len_hi = '0;
  logic         dropping = 1'b0;

  out_item_t    decoded_q[$];
  int           mismatches = 0;

  function automatic void restart_record();
    phase     = PH_VERSION;
    sets_left = '0;
    set_num   = '0;
    body_left = '0;
    len_hi    = '0;
    dropping  = 1'b0;
  endfunction

  // step past a finished set; true once the last PPS is done
  function automatic logic close_set(logic is_pps);
    set_num   = set_num + 8'd1;
    sets_left = sets_left - 8'd1;
    if (sets_left != 0) begin
      phase = is_pps ? PH_PPS_LEN_HI : PH_SPS_LEN_HI;
      return 1'b0;
    end
    set_num = '0;
    phase   = is_pps ? PH_COMPLETE : PH_PPSCOUNT;
    return is_pps;
  endfunction

  function automatic out_item_t decode_byte(in_item_t it);
    out_item_t  r;
    logic       reserved_bad;
    logic       is_pps;
    logic [7:0] b;
    b = it.data_byte;
    r = '0;
    r.item_kind   = KIND_IGNORED;
    r.field_value = {8'h00, b};
    r.status      = ST_OK;
    reserved_bad  = 1'b0;
    if (!dropping) begin
      case (phase)
        PH_VERSION: begin
          r.item_kind = KIND_VERSION;
          phase = PH_PROFILE;
        end
        PH_PROFILE: begin
          r.item_kind = KIND_PROFILE;
          phase = PH_COMPAT;
        end
        PH_COMPAT: begin
          r.item_kind = KIND_COMPAT;
          phase = PH_LEVEL;
        end
        PH_LEVEL: begin
          r.item_kind = KIND_LEVEL;
          phase = PH_LENSIZE;
        end
        PH_LENSIZE: begin
          r.item_kind   = KIND_LENSIZE;
          r.field_value = {14'd0, b[1:0]};
          if (b[7:2] != Res6Ones) begin
            r.status     = ST_RES6_BAD;
            reserved_bad = 1'b1;
            dropping     = 1'b1;
          end else begin
            phase = PH_SPSCOUNT;
          end
        end
        PH_SPSCOUNT: begin
          r.item_kind   = KIND_SPSCOUNT;
          r.field_value = {11'd0, b[4:0]};
          if (b[7:5] != Res3Ones) begin
            r.status     = ST_RES3_BAD;
            reserved_bad = 1'b1;
            dropping     = 1'b1;
          end else begin
            sets_left = {3'd0, b[4:0]};
            set_num   = '0;
            phase     = (b[4:0] == 0) ? PH_PPSCOUNT : PH_SPS_LEN_HI;
          end
        end
        PH_PPSCOUNT: begin
          r.item_kind = KIND_PPSCOUNT;
          sets_left   = b;
          set_num     = '0;
          if (b == 0) begin
            phase = PH_COMPLETE;
            r.record_complete = 1'b1;
          end else begin
            phase = PH_PPS_LEN_HI;
          end
        end
        PH_SPS_LEN_HI, PH_PPS_LEN_HI: begin
          r.item_kind = KIND_PENDING;
          r.set_index = set_num;
          len_hi      = b;
          phase = (phase == PH_SPS_LEN_HI) ? PH_SPS_LEN_LO : PH_PPS_LEN_LO;
        end
        PH_SPS_LEN_LO, PH_PPS_LEN_LO: begin
          is_pps          = (phase == PH_PPS_LEN_LO);
          r.item_kind     = KIND_LENGTH;
          r.set_index     = set_num;
          r.is_pps_length = is_pps;
          body_left       = {len_hi, b};
          r.field_value   = body_left;
          if (body_left == 0) begin
            r.last_of_set     = 1'b1;
            r.record_complete = close_set(is_pps);
          end else begin
            phase = is_pps ? PH_PPS_BODY : PH_SPS_BODY;
          end
        end
        PH_SPS_BODY, PH_PPS_BODY: begin
          is_pps      = (phase == PH_PPS_BODY);
          r.item_kind = is_pps ? KIND_PPSBYTE : KIND_SPSBYTE;
          r.set_index = set_num;
          body_left   = body_left - 16'd1;
          if (body_left == 0) begin
            r.last_of_set     = 1'b1;
            r.record_complete = close_set(is_pps);
          end
        end
        default: r.item_kind = KIND_IGNORED;
      endcase
      // a reserved-bit error outranks truncation on the same byte
      if (it.end_of_record && !reserved_bad && phase != PH_COMPLETE)
        r.status = ST_TRUNCATED;
    end
    if (it.end_of_record)
      restart_record();
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      restart_record();
      decoded_q.delete();
    end else begin
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          $error("result transfer with nothing expected");
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          check_field("item_kind", want.item_kind, result_o.item_kind);
          check_field("field_value", want.field_value, result_o.field_value);
          check_field("set_index", want.set_index, result_o.set_index);
          check_field("is_pps_length", want.is_pps_length, result_o.is_pps_length);
          check_field("last_of_set", want.last_of_set, result_o.last_of_set);
          check_field("status", want.status, result_o.status);
          check_field("record_complete", want.record_complete,
                      result_o.record_complete);
        end
      end
      if (push && !full)
        decoded_q = {decoded_q, decode_byte(item_i)};
    end
    mismatch_count_o <= mismatches;
    outstanding_o    <= decoded_q.size();
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import avcdcr_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push;
  in_item_t  item_i;
  logic      full;
  logic      empty;
  logic      pop;
  out_item_t result_o;
  int        mismatch_count;
  int        outstanding;

  in_item_t  rec_q[$];
  int        bytes_sent = 0;
  logic      calm = 1'b0;
  int        hold_req = 0;
  int        hold_done = 0;

  always #5 clk_i = ~clk_i;

  avc_decoder_config_record_parser uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .item_i   (item_i),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

  record_parse_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .item_i           (item_i),
    .full             (full),
    .empty            (empty),
    .pop              (pop),
    .result_o         (result_o),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  task automatic put(input logic [7:0] b);
    rec_q = {rec_q, in_item_t'{data_byte: b, end_of_record: 1'b0}};
  endtask

  task automatic put_sets(input int count, input int max_len);
    logic [15:0] len;
    repeat (count) begin
      len = 16'($urandom_range(0, max_len));
      put(len[15:8]);
      put(len[7:0]);
      repeat (len) put(8'($urandom));
    end
  endtask

  task automatic put_record(input int n_sps, input int n_pps, input int max_len);
    repeat (4) put(8'($urandom));
    put({Res6Ones, 2'($urandom)});
    put({Res3Ones, 5'(n_sps)});
    put_sets(n_sps, max_len);
    put(8'(n_pps));
    put_sets(n_pps, max_len);
  endtask

  // header then a length of any size, cut short after zero to four body bytes
  task automatic put_long_set();
    logic [7:0] b;
    repeat (4) put(8'($urandom));
    put({Res6Ones, 2'($urandom)});
    b = 8'($urandom);
    b[7:5] = Res3Ones;
    put(b);
    if (b[4:0] == 0)
      put(8'($urandom));
    put(8'($urandom));
    put(8'($urandom));
    repeat ($urandom_range(0, 4)) put(8'($urandom));
  endtask

  task automatic cut_to(input int keep);
    while (rec_q.size() > keep)
      void'(rec_q.pop_back());
  endtask

  task automatic send_byte(input in_item_t it);
    while (!calm && $urandom_range(99) < 31) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push   <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_record();
    rec_q[rec_q.size() - 1].end_of_record = 1'b1;
    foreach (rec_q[i]) send_byte(rec_q[i]);
    rec_q.delete();
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_done) begin
        pop <= 1'b0;
        repeat (80) @(posedge clk_i);
        hold_done = hold_req;
      end else begin
        pop <= calm || ($urandom_range(99) >= 31);
      end
    end
  end

  initial begin
    int pick;
    int n_sps;
    int n_pps;
    int rec_no;
    push   <= 1'b0;
    item_i <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // complete record: one SPS, one empty PPS, then a trailing byte
    put(8'h00); put(8'hFF); put(8'h5A); put(8'hA5);
    put(8'hFF); put(8'hE1);
    put(8'h00); put(8'h02); put(8'hAB); put(8'hCD);
    put(8'h01); put(8'h00); put(8'h00);
    put(8'hFF);
    send_record();
    // bad length-size reserved bits on the closing byte
    put(8'hFF); put(8'h00); put(8'hFF); put(8'h00);
    put(8'h03);
    send_record();
    // bad SPS-count reserved bits, then a dropped byte
    put(8'h01); put(8'h42); put(8'hC0); put(8'h1E);
    put(8'hFF); put(8'h1F); put(8'h55);
    send_record();
    drain();

    rec_no = 0;
    while (bytes_sent < 650) begin
      if (rec_no == 3)
        hold_req++;
      calm  = (rec_no >= 12 && rec_no < 24);
      pick  = $urandom_range(99);
      n_sps = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(3);
      n_pps = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(3);
      if (pick < 86)
        put_record(n_sps, n_pps, (n_sps + n_pps > 8) ? 2 : 6);
      if (pick < 60) begin
        if ($urandom_range(9) < 3)
          repeat ($urandom_range(1, 3)) put(8'($urandom));
      end else if (pick < 70) begin
        cut_to($urandom_range(1, rec_q.size()));
      end else if (pick < 78) begin
        rec_q[4].data_byte[7:2] = 6'($urandom_range(0, 62));
        cut_to($urandom_range(5, rec_q.size()));
      end else if (pick < 86) begin
        rec_q[5].data_byte[7:5] = 3'($urandom_range(0, 6));
        cut_to($urandom_range(6, rec_q.size()));
      end else if (pick < 93) begin
        put_long_set();
      end else begin
        repeat ($urandom_range(1, 12)) put(8'($urandom));
      end
      send_record();
      if (rec_no == 30)
        drain();
      rec_no++;
    end
    calm = 1'b0;

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("testbench: errors");
    $finish;
  end

endmodule
